// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/prb_pkg.sv
// ---------------------------------------------------------------------------
// prb_pkg
// Types and constants of the precision/recall breakeven block.
// ---------------------------------------------------------------------------
`default_nettype none
package prb_pkg;
    localparam int DEF_MAX_POINTS   = 64;
    localparam int DEF_COUNT_BITS   = 25;
    localparam int DEF_MAX_CHANNELS = 256;
    localparam int Q_BITS           = 17;
    localparam int PC_BITS          = 7;

    localparam logic [Q_BITS-1:0]  ONE_Q16  = 17'h10000;
    localparam logic [PC_BITS-1:0] PC_RESET = 7'd10;

    typedef struct packed {
        logic signed [15:0] score;
        logic [7:0]         label;
        logic               last_of_channel;
        logic               last_of_set;
    } t_in;

    typedef struct packed {
        logic [15:0] breakeven;
        logic [16:0] channel_loss;
        logic [16:0] mean_loss;
        logic        set_done;
    } t_out;

    typedef struct packed {
        logic inc;    // count one pixel in the addressed cell
        logic pos;    // pixel is labelled positive
        logic shift;  // move every cell up by one during the sweep
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: rtl/precision_recall_breakeven.sv
// ---------------------------------------------------------------------------
// precision_recall_breakeven
// Per-channel precision/recall breakeven and running mean loss.
// ---------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_data) takes one pixel word per cycle
// while a channel is being collected; each pixel with a non-negative score
// and label 0 or 1 is counted into a chain of MAX_POINTS+1 bin cells in the
// cycle after it is accepted. The word with last_of_channel closes the
// channel: o_ready drops and the cell chain is shifted out one threshold per
// step from the top, giving suffix sums. Each threshold in 0..K takes two
// parallel bit-serial divisions; after threshold 0 the loss division runs
// and the result is loaded into the output register; the shift also clears
// the bins.
// The result word (o_valid/i_ready, o_data) sits in an output register;
// pixels of the next channel are taken while it waits. A new close stalls
// at its end until the previous result has been taken.
// Reset (synchronous, i_rst_n low) clears bins and totals and sets
// point_count to 10. i_cfg_we writes point_count into a register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module precision_recall_breakeven import prb_pkg::*; #(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [PC_BITS-1:0]  i_cfg_data,
    input  wire                i_valid,
    output logic               o_ready,
    input  t_in                i_data,
    output logic               o_valid,
    input  wire                i_ready,
    output t_out               o_data
);
    localparam int PT_BITS  = $clog2(MAX_POINTS + 1);
    localparam int SUM_BITS = COUNT_BITS + PT_BITS;
    localparam int DB       = SUM_BITS + 1;
    localparam int CT_BITS  = $clog2(MAX_CHANNELS + 1);
    localparam int LS_BITS  = Q_BITS + CT_BITS;
    localparam int PW       = 15 + PT_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_FLUSH, S_SUM, S_DIV, S_EVAL, S_LOSS, S_MEAN, S_OUT
    } t_state;

    t_state               r_state;
    logic [PC_BITS-1:0]   r_pc;
    logic [COUNT_BITS-1:0] r_ptot;
    logic                 r_inc_v, r_inc_pos;
    logic [PT_BITS-1:0]   r_inc_idx, r_pidx;
    logic [SUM_BITS-1:0]  r_tp, r_fp;
    logic                 r_pz, r_rz, r_set;
    logic [Q_BITS-1:0]    r_best_d, r_best_pr;
    logic [LS_BITS-1:0]   r_ls;
    logic [CT_BITS-1:0]   r_ct;
    logic                 r_out_v;
    t_out                 r_out;

    // effective point count and bin index
    logic [PT_BITS-1:0]   w_k, w_idx;
    logic [PW-1:0]        w_prod;
    logic [PT_BITS:0]     w_idx_raw;
    logic                 w_acc, w_bin;

    always_comb begin
        if (r_pc == '0) w_k = PT_BITS'(1);
        else if (int'(r_pc) > MAX_POINTS) w_k = PT_BITS'(MAX_POINTS);
        else w_k = PT_BITS'(r_pc);
    end

    assign w_prod    = PW'(i_data.score[14:0]) * PW'(w_k);
    assign w_idx_raw = w_prod[PW-1:14];
    assign w_idx     = (w_idx_raw > {1'b0, w_k}) ? w_k : w_idx_raw[PT_BITS-1:0];
    assign o_ready   = (r_state == S_IDLE);
    assign w_acc     = i_valid && o_ready;
    assign w_bin     = !i_data.score[15] && (i_data.label == 8'd0 || i_data.label == 8'd1);

    // cell chain
    t_cell_ctl             w_ctl;
    logic [COUNT_BITS-1:0] w_pos [0:MAX_POINTS];
    logic [COUNT_BITS-1:0] w_neg [0:MAX_POINTS];

    assign w_ctl.inc   = r_inc_v;
    assign w_ctl.pos   = r_inc_pos;
    assign w_ctl.shift = (r_state == S_SUM);

    for (genvar g = 0; g <= MAX_POINTS; g++) begin : g_cell
        logic [COUNT_BITS-1:0] w_in_pos, w_in_neg;
        if (g == 0) begin : g_first
            assign w_in_pos = '0;
            assign w_in_neg = '0;
        end else begin : g_rest
            assign w_in_pos = w_pos[g-1];
            assign w_in_neg = w_neg[g-1];
        end
        prb_cell #(
            .P_INDEX(g), .IDX_BITS(PT_BITS), .COUNT_BITS(COUNT_BITS)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_idx(r_inc_idx),
            .i_pos(w_in_pos), .i_neg(w_in_neg), .o_pos(w_pos[g]), .o_neg(w_neg[g])
        );
    end

    // suffix sums and ratio operands
    logic [SUM_BITS-1:0] n_tp, n_fp, w_rmax;
    logic [DB-1:0]       w_pden, w_rden;
    logic                w_take, w_rdone, w_pdone, w_ldone;
    logic [Q_BITS-1:0]   w_pq, w_rq, w_lq, w_pr, w_rc, w_d, w_closs;
    logic [LS_BITS-1:0]  n_ls;
    logic [CT_BITS-1:0]  n_ct;
    logic                w_room;

    assign n_tp   = r_tp + SUM_BITS'(w_pos[MAX_POINTS]);
    assign n_fp   = r_fp + SUM_BITS'(w_neg[MAX_POINTS]);
    assign w_pden = DB'(n_tp) + DB'(n_fp);
    assign w_rmax = (SUM_BITS'(r_ptot) > n_tp) ? SUM_BITS'(r_ptot) : n_tp;
    assign w_rden = DB'(w_rmax);
    assign w_take = (r_state == S_SUM) && (r_pidx <= w_k);

    prb_div #(.A_BITS(DB), .B_BITS(DB), .SHIFT(16)) u_pdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_take), .i_a(DB'(n_tp)),
        .i_b(w_pden), .o_done(w_pdone), .o_q(w_pq)
    );
    prb_div #(.A_BITS(DB), .B_BITS(DB), .SHIFT(16)) u_rdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_take), .i_a(DB'(n_tp)),
        .i_b(w_rden), .o_done(w_rdone), .o_q(w_rq)
    );

    assign w_pr = r_pz ? ONE_Q16 : w_pq;
    assign w_rc = r_rz ? ONE_Q16 : w_rq;
    assign w_d  = (w_pr > w_rc) ? (w_pr - w_rc) : (w_rc - w_pr);

    // loss accumulation; channels past the cap leave the totals alone
    assign w_closs = ONE_Q16 - r_best_pr;
    assign w_room  = int'(r_ct) < MAX_CHANNELS;
    assign n_ls    = w_room ? r_ls + LS_BITS'(w_closs) : r_ls;
    assign n_ct    = w_room ? r_ct + 1'b1 : r_ct;

    prb_div #(.A_BITS(LS_BITS), .B_BITS(CT_BITS), .SHIFT(0)) u_ldiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_LOSS), .i_a(n_ls),
        .i_b(n_ct), .o_done(w_ldone), .o_q(w_lq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= PC_RESET;
            r_ptot   <= '0;
            r_inc_v  <= 1'b0;
            r_ls     <= '0;
            r_ct     <= '0;
            r_out_v  <= 1'b0;
            r_tp     <= '0;
            r_fp     <= '0;
            r_best_d <= ONE_Q16;
            r_best_pr <= '0;
            r_pidx   <= PT_BITS'(MAX_POINTS);
            r_pz     <= 1'b0;
            r_rz     <= 1'b0;
            r_set    <= 1'b0;
        end else begin
            if (i_cfg_we) r_pc <= i_cfg_data;
            // in S_OUT the load below decides the valid flag
            if (r_out_v && i_ready && r_state != S_OUT) r_out_v <= 1'b0;
            r_inc_v <= w_acc && w_bin;
            if (w_acc) begin
                r_inc_pos <= i_data.label[0];
                r_inc_idx <= w_idx;
                if (i_data.label == 8'd1 && r_ptot != '1) r_ptot <= r_ptot + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_data.last_of_channel) begin
                        r_set   <= i_data.last_of_set;
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_tp      <= '0;
                    r_fp      <= '0;
                    r_best_d  <= ONE_Q16;
                    r_best_pr <= '0;
                    r_pidx    <= PT_BITS'(MAX_POINTS);
                    r_state   <= S_SUM;
                end
                S_SUM: begin
                    if (w_take) begin
                        r_tp    <= n_tp;
                        r_fp    <= n_fp;
                        r_pz    <= (w_pden == '0);
                        r_rz    <= (w_rden == '0);
                        r_state <= S_DIV;
                    end else begin
                        r_pidx <= r_pidx - 1'b1;
                    end
                end
                S_DIV: begin
                    if (w_pdone) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    // descending scan with <= keeps the lowest threshold on ties
                    if (w_pr != '0 && !w_pr[Q_BITS-1] && w_rc != '0 && !w_rc[Q_BITS-1]
                        && w_d <= r_best_d) begin
                        r_best_d  <= w_d;
                        r_best_pr <= w_pr;
                    end
                    if (r_pidx == '0) begin
                        r_state <= S_LOSS;
                    end else begin
                        r_pidx  <= r_pidx - 1'b1;
                        r_state <= S_SUM;
                    end
                end
                S_LOSS: begin
                    r_ls    <= n_ls;
                    r_ct    <= n_ct;
                    r_ptot  <= '0;
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    if (w_ldone) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_v || i_ready) begin
                        r_out_v            <= 1'b1;
                        r_out.breakeven    <= r_best_pr[15:0];
                        r_out.channel_loss <= w_closs;
                        r_out.mean_loss    <= w_lq;
                        r_out.set_done     <= r_set;
                        if (r_set) begin
                            r_ls <= '0;
                            r_ct <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    `ASSERT_PROP(a_loss_sum, i_clk, i_rst_n,
        o_valid |-> (o_data.channel_loss == ONE_Q16 - {1'b0, o_data.breakeven}))
    `ASSERT_NEVER(a_ct_cap, i_clk, i_rst_n, int'(r_ct) > MAX_CHANNELS)
    `ASSERT_PROP(a_out_load, i_clk, i_rst_n,
        $rose(o_valid) |-> ($past(r_state) == S_OUT))
    `ASSERT_PROP(a_div_sync, i_clk, i_rst_n, w_pdone == w_rdone)
endmodule
`default_nettype wire

// File: rtl/prb_cell.sv
// ---------------------------------------------------------------------------
// prb_cell
// One threshold bin: positive and negative counters, shifted up on sweep.
// ---------------------------------------------------------------------------
`default_nettype none
module prb_cell import prb_pkg::*; #(
    parameter int P_INDEX    = 0,
    parameter int IDX_BITS   = 7,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  wire [IDX_BITS-1:0]     i_idx,
    input  wire [COUNT_BITS-1:0]   i_pos,
    input  wire [COUNT_BITS-1:0]   i_neg,
    output logic [COUNT_BITS-1:0]  o_pos,
    output logic [COUNT_BITS-1:0]  o_neg
);
    logic [COUNT_BITS-1:0] r_pos, r_neg;
    logic                  w_hit;

    assign w_hit = i_ctl.inc && (i_idx == IDX_BITS'(P_INDEX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_neg <= '0;
        end else if (i_ctl.shift) begin
            r_pos <= i_pos;
            r_neg <= i_neg;
        end else if (w_hit) begin
            if (i_ctl.pos) begin
                if (r_pos != '1) r_pos <= r_pos + 1'b1;
            end else begin
                if (r_neg != '1) r_neg <= r_neg + 1'b1;
            end
        end
    end

    assign o_pos = r_pos;
    assign o_neg = r_neg;
endmodule
`default_nettype wire

// File: rtl/prb_div.sv
// ---------------------------------------------------------------------------
// prb_div
// Bit-serial restoring divider: (a << SHIFT) / b, one dividend bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module prb_div import prb_pkg::*; #(
    parameter int A_BITS = 32,
    parameter int B_BITS = 32,
    parameter int SHIFT  = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire [A_BITS-1:0]  i_a,
    input  wire [B_BITS-1:0]  i_b,
    output logic              o_done,
    output logic [Q_BITS-1:0] o_q
);
    localparam int XW = A_BITS + SHIFT;
    localparam int CW = $clog2(XW + 1);

    logic [XW-1:0]     r_x, r_q;
    logic [B_BITS-1:0] r_rem, r_b;
    logic [CW-1:0]     r_cnt;
    logic              r_done;
    logic [B_BITS:0]   w_sh;
    logic              w_ge;

    assign w_sh = {r_rem, r_x[XW-1]};
    assign w_ge = w_sh >= {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x   <= XW'(i_a) << SHIFT;
                r_b   <= i_b;
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= CW'(XW);
            end else if (r_cnt != '0) begin
                r_x   <= r_x << 1;
                r_rem <= w_ge ? B_BITS'(w_sh - {1'b0, r_b}) : B_BITS'(w_sh);
                r_q   <= {r_q[XW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q[Q_BITS-1:0];
endmodule
`default_nettype wire
